// ----- rtl/ldf_pkg.sv -----
// Shared types and constants for the length-prefixed frame deframer.
package ldf_pkg;

  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned SizeBytes = 4;
  localparam int unsigned WorkBytes = 8;
  localparam int unsigned CntW      = 4;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [31:0] FrameSizeLimitRst   = 32'd65536;
  localparam logic [63:0] MessageWorkLimitRst = {64{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_SIZE_LIMIT   = 1'b0,
    CFG_MESSAGE_WORK_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_HEADER  = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_DONE    = 3'd2,
    EV_ERROR   = 3'd3,
    EV_CLEARED = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_TERMINATOR = 2'd1,
    ERR_TOO_LARGE  = 2'd2,
    ERR_WORK       = 2'd3
  } err_t;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    logic [31:0] frame_size_limit;
    logic [63:0] message_work_limit;
  } cfg_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  payload_byte;
    logic        frame_last;
    err_t        err;
    logic [63:0] work_tally;
  } result_t;

endpackage

// ----- rtl/length_prefixed_frame_deframer.sv -----
// Top level of the length-prefixed frame deframer.
// A word accepted into the input register is decoded and its result is held in the result register.
// Throughput: one word per cycle unless the input stalls; the result register decouples the sides.
// The input stalls only while a result is held and the staged word cannot move.
// Reset (rst_n low, synchronous) empties both registers, clears the decoder
// state and restores the limits to their defaults.
module length_prefixed_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_event_res,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_frame_last,
  output logic [1:0]                    out_error_code,
  output logic [63:0]                   out_work_tally,
  input  logic                          cfg_wr_en,
  input  logic [ldf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ldf_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ldf_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_opcode_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;
  logic       out_blocked, fire, in_take;

  ldf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ldf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .opcode    (s1_opcode_r),
    .data_byte (s1_byte_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_comb begin
    out_blocked = out_valid_r && out_stall;
    fire        = s1_valid_r && !out_blocked;
    in_stall    = s1_valid_r && out_blocked;
    in_take     = in_valid && !in_stall;

    s1_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r <= in_opcode;
      s1_byte_r   <= in_data_byte;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_res_r.ev;
  assign out_payload_byte = out_res_r.payload_byte;
  assign out_frame_last   = out_res_r.frame_last;
  assign out_error_code   = out_res_r.err;
  assign out_work_tally   = out_res_r.work_tally;

endmodule

// ----- rtl/ldf_cfg.sv -----
// Configuration register file for the deframer limits.
module ldf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ldf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ldf_pkg::CfgDataW-1:0]  cfg_wdata,
  output ldf_pkg::cfg_t                 cfg
);
  import ldf_pkg::*;

  logic [31:0] frame_size_limit_r;
  logic [63:0] message_work_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_limit_r   <= FrameSizeLimitRst;
      message_work_limit_r <= MessageWorkLimitRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_SIZE_LIMIT:   frame_size_limit_r   <= cfg_wdata[31:0];
        CFG_MESSAGE_WORK_LIMIT: message_work_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.frame_size_limit   = frame_size_limit_r;
  assign cfg.message_work_limit = message_work_limit_r;

endmodule

// ----- rtl/ldf_core.sv -----
// Deframer state and the per-word decode between the input and result registers.
module ldf_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             opcode,
  input  logic [7:0]       data_byte,
  input  ldf_pkg::cfg_t    cfg,
  output ldf_pkg::result_t res
);
  import ldf_pkg::*;

  localparam int unsigned HdrW = 8 * (HdrBytes - 1);
  localparam logic [CntW-1:0] HdrLast = CntW'(HdrBytes - 1);

  logic [CntW-1:0] header_count_r, header_count_nxt;
  logic [HdrW-1:0] hdr_r, hdr_nxt;
  logic [31:0]     remaining_r, remaining_nxt;
  logic [63:0]     work_total_r, work_total_nxt;
  logic            failed_r, failed_nxt;
  err_t            stored_err_r, stored_err_nxt;

  logic [8*SizeBytes-1:0] size;
  logic [8*WorkBytes-1:0] work;
  logic [64:0]            sum;
  logic [63:0]            sat_sum;

  always_comb begin
    size    = hdr_r[8*SizeBytes-1:0];
    work    = {data_byte, hdr_r[HdrW-1:8*SizeBytes]};
    sum     = {1'b0, work_total_r} + {1'b0, work};
    sat_sum = sum[64] ? {64{1'b1}} : sum[63:0];

    header_count_nxt = header_count_r;
    hdr_nxt          = hdr_r;
    remaining_nxt    = remaining_r;
    work_total_nxt   = work_total_r;
    failed_nxt       = failed_r;
    stored_err_nxt   = stored_err_r;

    res.ev           = EV_HEADER;
    res.payload_byte = 8'd0;
    res.frame_last   = 1'b0;
    res.err          = ERR_NONE;

    priority if (op_t'(opcode) == OP_CLEAR) begin
      header_count_nxt = '0;
      remaining_nxt    = '0;
      work_total_nxt   = '0;
      failed_nxt       = 1'b0;
      stored_err_nxt   = ERR_NONE;
      res.ev           = EV_CLEARED;
    end else if (failed_r) begin
      res.ev  = EV_ERROR;
      res.err = stored_err_r;
    end else if (remaining_r != 32'd0) begin
      remaining_nxt    = remaining_r - 32'd1;
      res.ev           = EV_PAYLOAD;
      res.payload_byte = data_byte;
      res.frame_last   = (remaining_r == 32'd1);
    end else begin
      hdr_nxt = {data_byte, hdr_r[HdrW-1:8]};
      if (header_count_r == HdrLast) begin
        header_count_nxt = '0;
        if (size == 32'd0) begin
          if (work != 64'd0) begin
            failed_nxt     = 1'b1;
            stored_err_nxt = ERR_TERMINATOR;
            remaining_nxt  = '0;
            res.ev         = EV_ERROR;
            res.err        = ERR_TERMINATOR;
          end else begin
            work_total_nxt = '0;
            res.ev         = EV_DONE;
          end
        end else begin
          work_total_nxt = sat_sum;
          priority if (size > cfg.frame_size_limit) begin
            failed_nxt     = 1'b1;
            stored_err_nxt = ERR_TOO_LARGE;
            remaining_nxt  = '0;
            res.ev         = EV_ERROR;
            res.err        = ERR_TOO_LARGE;
          end else if (sat_sum > cfg.message_work_limit) begin
            failed_nxt     = 1'b1;
            stored_err_nxt = ERR_WORK;
            remaining_nxt  = '0;
            res.ev         = EV_ERROR;
            res.err        = ERR_WORK;
          end else begin
            remaining_nxt = size;
          end
        end
      end else begin
        header_count_nxt = header_count_r + CntW'(1);
      end
    end

    res.work_tally = work_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      remaining_r    <= '0;
      work_total_r   <= '0;
      failed_r       <= 1'b0;
      stored_err_r   <= ERR_NONE;
    end else if (fire) begin
      header_count_r <= header_count_nxt;
      remaining_r    <= remaining_nxt;
      work_total_r   <= work_total_nxt;
      failed_r       <= failed_nxt;
      stored_err_r   <= stored_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

// ----- rtl/ldf_checker.sv -----
// Port-level checks for the deframer and their binding to the top level.
module ldf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_res,
  input logic        out_frame_last,
  input logic [1:0]  out_error_code,
  input logic [63:0] out_work_tally
);
  import ldf_pkg::*;

  a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_ERROR) |-> out_error_code == ERR_NONE)
    else $error("error code set on a non-error word");

  a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_event_res == EV_PAYLOAD)
    else $error("frame last mark on a non-payload word");

  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_event_res == EV_CLEARED) || (out_event_res == EV_DONE))
      |-> out_work_tally == 64'd0)
    else $error("work total not cleared at message end or clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_work_tally))
    else $error("stalled result word changed");

endmodule

bind length_prefixed_frame_deframer ldf_checker u_ldf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_res  (out_event_res),
  .out_frame_last (out_frame_last),
  .out_error_code (out_error_code),
  .out_work_tally (out_work_tally)
);

// ----- tb/deframer_checker.sv -----
// Checker that predicts every deframer result and compares it with the output channel.
`timescale 1ns / 100ps

module deframer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [7:0]                   in_data_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [2:0]                   out_event_res,
  input  logic [7:0]                   out_payload_byte,
  input  logic                         out_frame_last,
  input  logic [1:0]                   out_error_code,
  input  logic [63:0]                  out_work_tally,
  input  logic                         cfg_wr_en,
  input  logic [ldf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ldf_pkg::CfgDataW-1:0] cfg_wdata,
  output int                           failures,
  output int                           outstanding
);
  import ldf_pkg::*;

  logic [31:0]     size_limit;
  logic [63:0]     work_limit;
  logic [CntW-1:0] hdr_fill;
  logic [7:0]      hdr_bytes [HdrBytes];
  logic [31:0]     bytes_left;
  logic [63:0]     work_sum;
  logic            halted;
  err_t            held_err;

  result_t expected_events [$];

  function automatic void clear_decoder();
    hdr_fill   = '0;
    bytes_left = '0;
    work_sum   = '0;
    halted     = 1'b0;
    held_err   = ERR_NONE;
  endfunction

  function automatic void enter_halt(input err_t code);
    halted     = 1'b1;
    held_err   = code;
    bytes_left = '0;
  endfunction

  function automatic result_t deframe_word(input logic op, input logic [7:0] b);
    result_t     r;
    logic [31:0] size;
    logic [63:0] work;
    logic [64:0] sum;
    r.ev           = EV_HEADER;
    r.payload_byte = '0;
    r.frame_last   = 1'b0;
    r.err          = ERR_NONE;
    if (op == OP_CLEAR) begin
      clear_decoder();
      r.ev = EV_CLEARED;
    end else if (halted) begin
      r.ev  = EV_ERROR;
      r.err = held_err;
    end else if (bytes_left != 0) begin
      bytes_left     = bytes_left - 32'd1;
      r.ev           = EV_PAYLOAD;
      r.payload_byte = b;
      r.frame_last   = (bytes_left == 0);
    end else begin
      hdr_bytes[hdr_fill] = b;
      hdr_fill = hdr_fill + CntW'(1);
      if (int'(hdr_fill) >= HdrBytes) begin
        for (int i = 0; i < SizeBytes; i++) size[8*i +: 8] = hdr_bytes[i];
        for (int i = 0; i < WorkBytes; i++) work[8*i +: 8] = hdr_bytes[SizeBytes + i];
        hdr_fill = '0;
        if (size == 0) begin
          if (work != 0) begin
            enter_halt(ERR_TERMINATOR);
            r.ev  = EV_ERROR;
            r.err = ERR_TERMINATOR;
          end else begin
            work_sum = '0;
            r.ev     = EV_DONE;
          end
        end else begin
          sum      = {1'b0, work_sum} + {1'b0, work};
          work_sum = sum[64] ? {64{1'b1}} : sum[63:0];
          if (size > size_limit) begin
            enter_halt(ERR_TOO_LARGE);
            r.ev  = EV_ERROR;
            r.err = ERR_TOO_LARGE;
          end else if (work_sum > work_limit) begin
            enter_halt(ERR_WORK);
            r.ev  = EV_ERROR;
            r.err = ERR_WORK;
          end else begin
            bytes_left = size;
          end
        end
      end
    end
    r.work_tally = work_sum;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    logic    bad;
    if (!rst_n) begin
      size_limit = FrameSizeLimitRst;
      work_limit = MessageWorkLimitRst;
      clear_decoder();
      expected_events.delete();
      failures    = 0;
      outstanding = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_FRAME_SIZE_LIMIT) size_limit = cfg_wdata[31:0];
        else if (cfg_index == CFG_MESSAGE_WORK_LIMIT) work_limit = cfg_wdata[63:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with no word pending: ev=%0d work=%h", $realtime,
                     out_event_res, out_work_tally);
        end else begin
          want = expected_events.pop_front();
          bad = (want.ev !== out_event_res) || (want.payload_byte !== out_payload_byte) ||
                (want.frame_last !== out_frame_last) || (want.err !== out_error_code) ||
                (want.work_tally !== out_work_tally);
          if (bad) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: expected ev=%0d byte=%h last=%0d err=%0d work=%h,",
                       $realtime, want.ev, want.payload_byte, want.frame_last, want.err,
                       want.work_tally,
                       " got ev=%0d byte=%h last=%0d err=%0d work=%h",
                       out_event_res, out_payload_byte, out_frame_last,
                       out_error_code, out_work_tally);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_events.push_back(deframe_word(in_opcode, in_data_byte));
      outstanding = expected_events.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the deframer testbench: clock, reset, stimulus, flow control and the verdict.
`timescale 1ns / 100ps

module testbench;
  import ldf_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TotalWords = 1450;
  localparam int unsigned PhaseCount = 5;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_opcode;
  logic [7:0]          in_data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          out_event_res;
  logic [7:0]          out_payload_byte;
  logic                out_frame_last;
  logic [1:0]          out_error_code;
  logic [63:0]         out_work_tally;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int          failures;
  int          outstanding;
  int unsigned words_sent;
  int unsigned cycle_count = 0;
  logic        idle_on;
  logic        hold_request;
  logic [31:0] size_lim_now;
  logic [63:0] work_lim_now;

  length_prefixed_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_frame_last   (out_frame_last),
    .out_error_code   (out_error_code),
    .out_work_tally   (out_work_tally),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  deframer_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_frame_last   (out_frame_last),
    .out_error_code   (out_error_code),
    .out_work_tally   (out_work_tally),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .failures         (failures),
    .outstanding      (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls at random while idle_on, and once holds off long so the block fills up.
  initial begin
    int unsigned hold_cnt;
    logic        hold_served;
    hold_cnt    = 0;
    hold_served = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_cnt    = 300;
        hold_served = 1'b1;
      end
      if (hold_cnt != 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 15);
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_clear();
    send_word(OP_CLEAR, 8'($urandom_range(255)));
  endtask

  task automatic send_bytes(input int unsigned n);
    repeat (n) send_word(OP_DATA, 8'($urandom_range(255)));
  endtask

  task automatic send_header(input logic [31:0] size, input logic [63:0] work);
    for (int i = 0; i < SizeBytes; i++) send_word(OP_DATA, size[8*i +: 8]);
    for (int i = 0; i < WorkBytes; i++) send_word(OP_DATA, work[8*i +: 8]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] size_lim, input logic [63:0] work_lim);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_SIZE_LIMIT;
    cfg_wdata <= {32'd0, size_lim};
    @(posedge clk);
    cfg_index <= CFG_MESSAGE_WORK_LIMIT;
    cfg_wdata <= work_lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    size_lim_now = size_lim;
    work_lim_now = work_lim;
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    int unsigned cap;
    int unsigned sz;
    logic [31:0] big_size;
    logic [63:0] wk;
    logic [63:0] msg_work;
    logic [63:0] budget;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = OP_DATA;
    in_data_byte = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_FRAME_SIZE_LIMIT;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    words_sent   = 0;
    size_lim_now = FrameSizeLimitRst;
    work_lim_now = MessageWorkLimitRst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      case (p)
        1: set_limits(32'd0, 64'd0);
        2: set_limits({32{1'b1}}, {64{1'b1}});
        3: set_limits(32'($urandom_range(1, 16)), 64'($urandom_range(0, 5000)));
        4: set_limits(32'd5, {$urandom(), $urandom()});
        default: ;
      endcase
      idle_on      = (p != 2);
      hold_request = hold_request || (p == 1);

      if (p == 0) begin
        send_clear();
        send_header(32'd2, {64{1'b1}});
        send_word(OP_DATA, 8'h00);
        send_word(OP_DATA, 8'hFF);
        send_header(32'd0, 64'd0);
      end

      target = (p + 1) * TotalWords / PhaseCount;
      while (words_sent < target) begin
        pick = $urandom_range(99);
        cap  = (size_lim_now < 8) ? int'(size_lim_now) : 8;
        if (pick < 50) begin
          // Frames within the work limit, some past the size limit, then a terminator.
          msg_work = '0;
          if (cap != 0) begin
            repeat ($urandom_range(1, 3)) begin
              sz = $urandom_range(1, cap);
              if (cap == 8 && $urandom_range(19) == 0) sz = $urandom_range(9, 40);
              budget = work_lim_now - msg_work;
              if ($urandom_range(3) == 0) wk = '0;
              else if (budget > 1000) wk = 64'($urandom_range(0, 1000));
              else wk = 64'($urandom_range(0, int'(budget[31:0])));
              msg_work = msg_work + wk;
              send_header(32'(sz), wk);
              send_bytes(sz);
            end
          end
          send_header(32'd0, 64'd0);
        end else if (pick < 60) begin
          wk = {$urandom(), $urandom()} | (64'd1 << $urandom_range(63));
          send_header(32'd0, wk);
          send_bytes($urandom_range(1, 4));
          send_clear();
        end else if (pick < 70) begin
          if (size_lim_now == {32{1'b1}}) begin
            send_header(32'd0, {$urandom(), $urandom()} | 64'd1);
          end else begin
            big_size = $urandom();
            if (big_size <= size_lim_now) big_size = size_lim_now + 1;
            send_header(big_size, {$urandom(), $urandom()});
          end
          send_bytes($urandom_range(1, 4));
          send_clear();
        end else if (pick < 85) begin
          // Work beyond the budget where it can be exceeded, else a saturating total.
          sz = (cap == 0) ? 1 : $urandom_range(1, cap);
          if (work_lim_now != {64{1'b1}}) begin
            wk = {$urandom(), $urandom()};
            if (wk <= work_lim_now) wk = work_lim_now + 1;
            send_header(32'(sz), wk);
            send_bytes($urandom_range(1, 4));
          end else begin
            send_header(32'(sz), {64{1'b1}} - 64'($urandom_range(0, 15)));
            send_bytes(sz);
            send_header(32'(sz), {$urandom(), $urandom()} | (64'd1 << 63));
            send_bytes(sz);
            send_header(32'd0, 64'd0);
          end
          send_clear();
        end else if (pick < 95) begin
          repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(9) == 0) send_clear();
            else send_word(OP_DATA, 8'($urandom_range(255)));
          end
          send_clear();
        end else begin
          // A clear that cuts into a header or into a payload.
          if ($urandom_range(1) == 0 || cap == 0) begin
            send_bytes($urandom_range(1, 11));
          end else begin
            sz = $urandom_range(2, 8);
            if (sz > cap) sz = cap;
            send_header(32'(sz), 64'd0);
            send_bytes($urandom_range(0, sz - 1));
          end
          send_clear();
        end
      end
    end

    drain();
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
